// File: rtl/cfbse_pkg.sv
package cfbse_pkg;

    // Frame marker and escape codes on the serial line.
    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] ESC_BYTE   = 8'hFE;
    localparam logic [7:0] ESC_OF_FF  = 8'hFE;
    localparam logic [7:0] ESC_OF_FE  = 8'hFD;

    localparam int ID_BYTES             = 4;
    localparam int HDR_CELLS            = 2 + ID_BYTES;
    localparam int DATA_FIELDS          = 8;
    localparam int MAX_DATA_BYTES_DEF   = 8;
    localparam int LEN_W                = 4;
    localparam int CNT_W                = 5;

    // One frame byte held in a cell. When esc is set, the cell first sends
    // the escape prefix and then code, which already holds the second byte.
    typedef struct packed {
        logic       valid;
        logic       esc;
        logic       last;
        logic [7:0] code;
    } t_cell;

    typedef struct packed {
        logic load;
        logic shift;
        logic unesc;
    } t_cell_ctl;

    function automatic t_cell plain_cell(logic [7:0] b, logic v, logic l);
        t_cell c;
        c.valid = v;
        c.esc   = 1'b0;
        c.last  = l;
        c.code  = b;
        return c;
    endfunction

    function automatic t_cell escaped_cell(logic [7:0] b, logic v, logic l);
        t_cell c;
        c.valid = v;
        c.last  = l;
        c.esc   = (b == START_BYTE) || (b == ESC_BYTE);
        c.code  = (b == START_BYTE) ? ESC_OF_FF :
                  (b == ESC_BYTE)   ? ESC_OF_FE : b;
        return c;
    endfunction

endpackage

// File: rtl/cfbse_cell.sv
module cfbse_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfbse_pkg::t_cell_ctl  i_ctl,
    input  cfbse_pkg::t_cell      i_load_val,
    input  cfbse_pkg::t_cell      i_neighbor,
    output cfbse_pkg::t_cell      o_cell
);

    cfbse_pkg::t_cell r_cell;
    cfbse_pkg::t_cell n_cell;

    always_comb begin
        n_cell = r_cell;
        priority if (i_ctl.load) begin
            n_cell = i_load_val;
        end else if (i_ctl.shift) begin
            n_cell = i_neighbor;
        end else if (i_ctl.unesc) begin
            n_cell.esc = 1'b0;
        end else begin
            n_cell = r_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// File: rtl/can_frame_byte_stuff_encoder.sv
// The start byte is shown on the output in the cycle after a message transaction.
// Throughput: one frame byte per cycle while the output accepts. A frame is 6 to
// 2 + 2 * (4 + MAX_DATA_BYTES) bytes long (26 at the default); the rate is set by the single
// output byte drained from the head of the cell row.
// The next message is taken in the cycle the last byte of the current frame leaves.
// Reset (synchronous, active low) empties every cell; no frame is in flight afterwards.
module can_frame_byte_stuff_encoder #(
    parameter int MAX_DATA_BYTES = cfbse_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // From bit 0 up: msg_id[31:0], data_len[35:32], data_0[43:36], data_1[51:44],
    // data_2[59:52], data_3[67:60], data_4[75:68], data_5[83:76], data_6[91:84],
    // data_7[99:92], zero fill[103:100].
    input  logic [103:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // From bit 0 up: out_byte[7:0].
    output logic [7:0]   o_m_axis_tdata,
    // frame_end: marks the final byte of the frame.
    output logic         o_m_axis_tlast
);

    // The row holds the whole frame before stuffing: start byte, length byte,
    // four identifier bytes and the data bytes. Each cell carries one byte and
    // knows whether it still owes an escape prefix. Cell 0 is the head and
    // drives the output; the row shifts toward it one cell per fully sent head cell.
    localparam int NCELLS = cfbse_pkg::HDR_CELLS + MAX_DATA_BYTES;

    cfbse_pkg::t_cell     w_cell [NCELLS];
    cfbse_pkg::t_cell     w_load [NCELLS];
    cfbse_pkg::t_cell_ctl w_ctl  [NCELLS];

    logic [31:0] w_id;
    logic [cfbse_pkg::LEN_W-1:0] w_len_in;
    logic [cfbse_pkg::LEN_W-1:0] w_len;
    logic [cfbse_pkg::CNT_W-1:0] w_used;
    logic [7:0]  w_data [cfbse_pkg::DATA_FIELDS];
    logic        w_in_take;
    logic        w_out_take;

    assign w_id     = i_s_axis_tdata[31:0];
    assign w_len_in = i_s_axis_tdata[35:32];

    // Lengths above the configured maximum are clamped; the length byte
    // reports the four identifier bytes plus the clamped count.
    assign w_len = (w_len_in > cfbse_pkg::LEN_W'(MAX_DATA_BYTES)) ?
                   cfbse_pkg::LEN_W'(MAX_DATA_BYTES) : w_len_in;
    // Number of cells the frame occupies before stuffing.
    assign w_used = cfbse_pkg::CNT_W'(cfbse_pkg::HDR_CELLS) + cfbse_pkg::CNT_W'(w_len);

    for (genvar d = 0; d < cfbse_pkg::DATA_FIELDS; d++) begin : g_data
        assign w_data[d] = i_s_axis_tdata[36 + 8*d +: 8];
    end

    // A head byte leaves on every output transaction. If it still owes the
    // escape prefix, only the prefix leaves and the row holds.
    assign o_m_axis_tvalid = w_cell[0].valid;
    assign o_m_axis_tdata  = w_cell[0].esc ? cfbse_pkg::ESC_BYTE : w_cell[0].code;
    assign o_m_axis_tlast  = w_cell[0].last && !w_cell[0].esc;
    assign w_out_take      = o_m_axis_tvalid && i_m_axis_tready;

    // Valid cells always sit contiguously from the head, so an empty head
    // means an empty row. A new message is also taken while the final byte
    // of the previous frame leaves.
    assign o_s_axis_tready = !w_cell[0].valid || (w_out_take && o_m_axis_tlast);
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        if (k == 0) begin : g_start
            assign w_load[k] = cfbse_pkg::plain_cell(cfbse_pkg::START_BYTE, 1'b1, 1'b0);
        end else if (k == 1) begin : g_length
            // The length byte is never escaped.
            assign w_load[k] = cfbse_pkg::plain_cell(
                8'(cfbse_pkg::ID_BYTES) + 8'(w_len), 1'b1, 1'b0);
        end else if (k < cfbse_pkg::HDR_CELLS) begin : g_ident
            localparam logic [cfbse_pkg::CNT_W-1:0] KIDX = cfbse_pkg::CNT_W'(k);
            // Identifier goes out little-endian. With no data bytes the top
            // identifier byte closes the frame.
            assign w_load[k] = cfbse_pkg::escaped_cell(w_id[8*(k-2) +: 8], 1'b1,
                (KIDX + cfbse_pkg::CNT_W'(1)) == w_used);
        end else begin : g_payload
            localparam logic [cfbse_pkg::CNT_W-1:0] KIDX = cfbse_pkg::CNT_W'(k);
            assign w_load[k] = cfbse_pkg::escaped_cell(
                w_data[k - cfbse_pkg::HDR_CELLS], KIDX < w_used,
                (KIDX + cfbse_pkg::CNT_W'(1)) == w_used);
        end

        assign w_ctl[k].load  = w_in_take;
        assign w_ctl[k].shift = w_out_take && !w_cell[0].esc;
        assign w_ctl[k].unesc = (k == 0) && w_out_take && w_cell[0].esc;

        if (k == NCELLS - 1) begin : g_tail
            cfbse_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[k]),
                .i_load_val (w_load[k]),
                .i_neighbor ('0),
                .o_cell     (w_cell[k])
            );
        end else begin : g_body
            cfbse_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[k]),
                .i_load_val (w_load[k]),
                .i_neighbor (w_cell[k+1]),
                .o_cell     (w_cell[k])
            );
        end
    end

endmodule

// File: rtl/cfbse_checker.sv
module cfbse_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [7:0]   o_m_axis_tdata,
    input logic         o_m_axis_tlast
);

    // An offered output byte stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output transaction changed while stalled");

    // Every frame opens with the start byte in the cycle after its message.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=>
            o_m_axis_tvalid && o_m_axis_tdata == cfbse_pkg::START_BYTE && !o_m_axis_tlast)
        else $error("frame did not open with the start byte");

    // A frame is at least six bytes, so no second message is taken right away.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("message taken while a frame was in flight");

    // The last byte of a frame is never the unescaped start byte.
    a_last_not_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata != cfbse_pkg::START_BYTE)
        else $error("frame ended on a start byte");

endmodule

bind can_frame_byte_stuff_encoder cfbse_checker u_cfbse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: tb/can_frame_byte_stuff_encoder_tb.sv
module can_frame_byte_stuff_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is built at its default size, so the clamp limit comes from the package.
    localparam int MAX_DATA = cfbse_pkg::MAX_DATA_BYTES_DEF;
    // The worst correct run is about 125 messages of 26 bytes with long receiver stalls
    // and sender gaps, so this limit leaves ample margin.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to idle after the last expected byte, so that stray output is still seen.
    localparam int DRAIN_CYCLES = 40;

    // One byte of an encoded frame as it should leave the block.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // From bit 0 up: msg_id[31:0], data_len[35:32], data_0[43:36] .. data_7[99:92],
    // zero fill[103:100].
    logic [103:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // From bit 0 up: out_byte[7:0].
    logic [7:0]   o_m_axis_tdata;
    // frame_end: marks the final byte of the frame.
    logic         o_m_axis_tlast;

    logic [103:0] msg_q[$];       // messages waiting to be offered to the block
    t_frame_byte  frame_q[$];     // encoded bytes that the block still owes us
    int           error_count = 0;
    int           cycle_count = 0;

    can_frame_byte_stuff_encoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Builds the expected serial frame of one message and queues it byte by byte.
    // The start byte and the length byte go out as they are. Every identifier and
    // data byte is stuffed so that no raw start byte can appear inside the payload.
    task automatic predict_frame(input logic [103:0] msg);
        logic [7:0]  payload [0:11];
        logic [7:0]  enc [0:25];
        int          len;
        int          n;
        int          k;
        t_frame_byte fb;
        len = int'(msg[35:32]);
        if (len > MAX_DATA) begin
            len = MAX_DATA;
        end
        for (k = 0; k < cfbse_pkg::ID_BYTES; k++) begin
            payload[k] = msg[8*k +: 8];
        end
        // Data bytes at or beyond the clamped length are dropped here.
        for (k = 0; k < len; k++) begin
            payload[cfbse_pkg::ID_BYTES + k] = msg[36 + 8*k +: 8];
        end
        enc[0] = cfbse_pkg::START_BYTE;
        enc[1] = 8'(cfbse_pkg::ID_BYTES + len);
        n = 2;
        for (k = 0; k < cfbse_pkg::ID_BYTES + len; k++) begin
            if (payload[k] == cfbse_pkg::START_BYTE) begin
                enc[n]     = cfbse_pkg::ESC_BYTE;
                enc[n + 1] = cfbse_pkg::ESC_OF_FF;
                n += 2;
            end else if (payload[k] == cfbse_pkg::ESC_BYTE) begin
                enc[n]     = cfbse_pkg::ESC_BYTE;
                enc[n + 1] = cfbse_pkg::ESC_OF_FE;
                n += 2;
            end else begin
                enc[n] = payload[k];
                n += 1;
            end
        end
        for (k = 0; k < n; k++) begin
            fb.data = enc[k];
            fb.last = (k == n - 1);
            frame_q.push_back(fb);
        end
    endtask

    // Byte source biased toward the two codes that get stuffed and their neighbor.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: begin
                return cfbse_pkg::START_BYTE;
            end
            1: begin
                return cfbse_pkg::ESC_BYTE;
            end
            2: begin
                return cfbse_pkg::ESC_OF_FE;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    function automatic logic [103:0] pack_msg(logic [31:0] id, logic [3:0] len,
                                              logic [63:0] data);
        return {4'b0000, data, len, id};
    endfunction

    // Driver. Messages go out in bursts of random length with random gaps between
    // them. A message held on the bus stays put until its transaction completes, and
    // the prediction is made at that very edge from the data that was taken.
    int           burst_left = 1;
    int           gap_left = 0;
    always @(posedge i_clk) begin
        logic         held;
        logic         next_valid;
        logic [103:0] next_data;
        next_valid = 1'b0;
        next_data  = '0;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            held = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_frame(i_s_axis_tdata);
                held = 1'b0;
            end
            if (!held) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (msg_q.size() > 0) begin
                    next_valid = 1'b1;
                    next_data  = msg_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        // A quarter of the bursts run straight into the next one.
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
                i_s_axis_tvalid <= next_valid;
                if (next_valid) begin
                    i_s_axis_tdata <= next_data;
                end
            end
        end
    end

    // Receiver stalls. The output side switches among a few behaviors on segments of
    // random length: always ready, even odds, rare stalls, and mostly stalled.
    int           stall_mode = 0;
    int           segment_left = 0;
    always @(posedge i_clk) begin
        logic ready_next;
        if (segment_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            segment_left = $urandom_range(10, 200);
        end else begin
            segment_left--;
        end
        case (stall_mode)
            0: begin
                ready_next = 1'b1;
            end
            1: begin
                ready_next = 1'($urandom_range(0, 1));
            end
            2: begin
                ready_next = ($urandom_range(0, 7) != 0);
            end
            default: begin
                ready_next = ($urandom_range(0, 15) == 0);
            end
        endcase
        i_m_axis_tready <= ready_next;
    end

    // Monitor. Every output transaction is matched against the oldest expected byte.
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (frame_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = frame_q.pop_front();
                if (o_m_axis_tdata !== want.data) begin
                    report_mismatch($sformatf("byte %02h, expected %02h",
                                              o_m_axis_tdata, want.data));
                end
                if (o_m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("frame end %0b, expected %0b on byte %02h",
                                              o_m_axis_tlast, want.last, want.data));
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] id;
        logic [63:0] data;
        int          k;
        int          j;

        // Directed messages: empty frame, stuffed identifiers, every length code
        // including the ones that get clamped, and data beyond the length.
        msg_q.push_back(pack_msg(32'h0000_0000, 4'd0, 64'h0));
        msg_q.push_back(pack_msg(32'hFFFF_FFFF, 4'd0, 64'h0));
        msg_q.push_back(pack_msg(32'hFEFE_FEFE, 4'd8, {8{cfbse_pkg::ESC_BYTE}}));
        msg_q.push_back(pack_msg(32'hFDFD_FDFD, 4'd8, {8{cfbse_pkg::START_BYTE}}));
        for (k = 1; k <= 15; k++) begin
            for (j = 0; j < 8; j++) begin
                data[8*j +: 8] = pick_byte();
            end
            id = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
            msg_q.push_back(pack_msg(id, 4'(k), data));
        end
        // Unused data bytes are full of start codes and must not appear.
        msg_q.push_back(pack_msg(32'h1234_5678, 4'd0, {8{cfbse_pkg::START_BYTE}}));
        msg_q.push_back(pack_msg(32'h0000_0001, 4'd3, 64'hFFFF_FFFF_FF03_0201));
        msg_q.push_back(pack_msg(32'hFF00_FE7F, 4'd8, 64'hFE01_807F_00FD_FEFF));
        // Longest frame: every payload byte stuffed and the length clamped.
        msg_q.push_back(pack_msg(32'hFFFF_FFFF, 4'd15, {8{cfbse_pkg::START_BYTE}}));

        // Random messages with stuffing-prone content.
        for (k = 0; k < 100; k++) begin
            for (j = 0; j < 8; j++) begin
                data[8*j +: 8] = pick_byte();
            end
            id = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
            msg_q.push_back(pack_msg(id, 4'($urandom_range(0, 15)), data));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every message has been taken and every frame byte has arrived.
        while (msg_q.size() > 0 || i_s_axis_tvalid || frame_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (frame_q.size() != 0) begin
            report_mismatch($sformatf("%0d frame bytes never arrived", frame_q.size()));
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: can_frame_byte_stuff_encoder.f
rtl/cfbse_pkg.sv
rtl/cfbse_cell.sv
rtl/can_frame_byte_stuff_encoder.sv
rtl/cfbse_checker.sv
tb/can_frame_byte_stuff_encoder_tb.sv
